>>> src/residue_mask_range_sieve_assert.svh
// Assertion macros for the residue mask range sieve checker.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef RESIDUE_MASK_RANGE_SIEVE_ASSERT_SVH
`define RESIDUE_MASK_RANGE_SIEVE_ASSERT_SVH

// Same-cycle implication, checked out of reset
`define RMS_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sieve check failed: same-cycle implication");

// Next-cycle implication, checked out of reset
`define RMS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sieve check failed: next-cycle implication");

`endif

>>> src/rms_pkg.sv
// Shared constants, action codes and controller/datapath interface types
// for the residue mask range sieve. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package rms_pkg;

    // Field widths fixed by the port definition
    localparam int ACTION_W  = 2;
    localparam int RESIDUE_W = 13;
    localparam int MODULUS_W = 14;
    localparam int QUERY_W   = 12;
    localparam int SURV_W    = 12;
    localparam int HALF_W    = 11;

    // Parameter defaults and register reset value
    localparam int MAX_HALF_RANGE_DEF = 2047;
    localparam int MAX_MODULUS_DEF    = 8192;
    localparam int RANGE_HALF_RESET   = 2047;

    typedef enum logic [ACTION_W-1:0] {
        ACT_START = 2'd0,
        ACT_MASK  = 2'd1,
        ACT_SWEEP = 2'd2,
        ACT_QUERY = 2'd3
    } rms_action_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic latch_half;
        logic fill;
        logic mask_write;
        logic div_init;
        logic div_step;
        logic r_init;
        logic sweep_issue;
        logic query_issue;
        logic finish;
        logic fin_query;
        logic fin_error;
    } rms_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic idx_last;
        logic div_last;
        logic mod_bad;
        logic q_out;
    } rms_status_t;

endpackage

`default_nettype wire

>>> src/rms_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module rms_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 2
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write and read in the same cycle; read data appears in the next cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

>>> src/rms_ctrl.sv
// Controller state machine of the residue mask range sieve.
// Depends on rms_pkg for action codes and the command/status types.
`timescale 1ns / 1ps
`default_nettype none

module rms_ctrl (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                start,
    input  wire logic [rms_pkg::ACTION_W-1:0]        action,
    input  wire rms_pkg::rms_status_t                sts,
    output rms_pkg::rms_cmd_t                        cmd,
    output logic                                     busy
);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_FILL  = 7'b0000010,
        S_DIV   = 7'b0000100,
        S_RINIT = 7'b0001000,
        S_SWEEP = 7'b0010000,
        S_DRAIN = 7'b0100000,
        S_QWAIT = 7'b1000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Hold state; return to idle on reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Decode commands and next state
    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    unique case (rms_pkg::rms_action_t'(action))
                        rms_pkg::ACT_START:
                        begin
                            cmd.latch_half = 1'b1;
                            state_next     = S_FILL;
                        end
                        rms_pkg::ACT_MASK:
                        begin
                            cmd.mask_write = 1'b1;
                            cmd.finish     = 1'b1;
                        end
                        rms_pkg::ACT_SWEEP:
                        begin
                            if (sts.mod_bad)
                            begin
                                cmd.finish = 1'b1;
                            end
                            else
                            begin
                                cmd.div_init = 1'b1;
                                state_next   = S_DIV;
                            end
                        end
                        rms_pkg::ACT_QUERY:
                        begin
                            if (sts.q_out)
                            begin
                                cmd.finish    = 1'b1;
                                cmd.fin_error = 1'b1;
                            end
                            else
                            begin
                                cmd.query_issue = 1'b1;
                                state_next      = S_QWAIT;
                            end
                        end
                    endcase
                end
            end
            S_FILL:
            begin
                cmd.fill = 1'b1;
                if (sts.idx_last)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_last)
                begin
                    state_next = S_RINIT;
                end
            end
            S_RINIT:
            begin
                cmd.r_init = 1'b1;
                state_next = S_SWEEP;
            end
            S_SWEEP:
            begin
                cmd.sweep_issue = 1'b1;
                if (sts.idx_last)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                cmd.finish = 1'b1;
                state_next = S_IDLE;
            end
            S_QWAIT:
            begin
                cmd.finish    = 1'b1;
                cmd.fin_query = 1'b1;
                state_next    = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);

endmodule

`default_nettype wire

>>> src/rms_datapath.sv
// Datapath of the residue mask range sieve: alive map, kill mask, survivor
// count, start-residue divider and result registers. Depends on rms_pkg, rms_ram.
`timescale 1ns / 1ps
`default_nettype none

module rms_datapath #(
    parameter int MAX_HALF_RANGE = rms_pkg::MAX_HALF_RANGE_DEF,
    parameter int MAX_MODULUS    = rms_pkg::MAX_MODULUS_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire rms_pkg::rms_cmd_t                   cmd,
    output rms_pkg::rms_status_t                     sts,
    input  wire logic [rms_pkg::RESIDUE_W-1:0]       residue,
    input  wire logic                                kill_bit,
    input  wire logic [rms_pkg::MODULUS_W-1:0]       modulus,
    input  wire logic signed [rms_pkg::QUERY_W-1:0]  query_n,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [rms_pkg::HALF_W-1:0]          cfg_data,
    output logic                                     done,
    output logic [rms_pkg::SURV_W-1:0]               survivors,
    output logic                                     alive_bit,
    output logic                                     range_error
);

    localparam int HW   = $clog2(MAX_HALF_RANGE + 1);
    localparam int AW   = HW + 1;
    localparam int SPAN = 2 * MAX_HALF_RANGE + 1;
    localparam int MW   = $clog2(MAX_MODULUS);
    localparam int DW   = MW + 2;
    localparam int BCW  = (HW > 1) ? $clog2(HW) : 1;
    localparam int CW   = (HW + 2 > rms_pkg::QUERY_W + 1) ? HW + 2 : rms_pkg::QUERY_W + 1;
    localparam int RESET_HALF = (rms_pkg::RANGE_HALF_RESET > MAX_HALF_RANGE) ?
                                MAX_HALF_RANGE : rms_pkg::RANGE_HALF_RESET;

    // Control state
    logic [rms_pkg::HALF_W-1:0] range_half_reg;
    logic [HW-1:0]              active_half_reg;
    logic                       started_reg;
    logic [AW-1:0]              count_reg;
    logic [AW-1:0]              count_next;
    logic                       p_valid_reg;
    logic                       done_reg;

    // Working registers
    logic [AW-1:0]              idx_reg;
    logic [AW-1:0]              p_idx_reg;
    logic [MW:0]                m_reg;
    logic [DW-1:0]              rem_reg;
    logic [DW-1:0]              rem_next;
    logic [BCW-1:0]             bit_reg;
    logic [MW-1:0]              r_reg;
    logic [MW-1:0]              r_step;
    logic [MW-1:0]              r_start;

    // Result registers
    logic [rms_pkg::SURV_W-1:0] survivors_reg;
    logic                       alive_reg;
    logic                       error_reg;

    // Combinational helpers
    logic [31:0]                rh_ext;
    logic [HW-1:0]              h_new;
    logic [AW-1:0]              last_idx;
    logic [31:0]                res_ext;
    logic                       res_ok;
    logic [31:0]                mod_ext;
    logic signed [CW-1:0]       q_s;
    logic signed [CW-1:0]       h_s;
    logic signed [CW-1:0]       q_sum;
    logic [AW-1:0]              q_addr;
    logic [DW-1:0]              trial;
    logic [DW-1:0]              m_wide;
    logic [MW:0]                rem_low;
    logic [MW:0]                m_diff;
    logic [MW:0]                r_inc;
    logic                       kill_hit;
    logic [31:0]                cnt_ext;

    // Memory ports
    logic                       alive_wr_en;
    logic [AW-1:0]              alive_wr_addr;
    logic                       alive_wr_data;
    logic [AW-1:0]              alive_rd_addr;
    logic                       alive_rd;
    logic                       kill_wr_en;
    logic                       kill_rd;

    // Effective half range from the register, clipped to the store size
    assign rh_ext   = 32'(range_half_reg);
    assign h_new    = (rh_ext > 32'(MAX_HALF_RANGE)) ? HW'(MAX_HALF_RANGE) : rh_ext[HW-1:0];
    assign last_idx = {active_half_reg, 1'b0};

    // Item checks
    assign res_ext = 32'(residue);
    assign res_ok  = (res_ext < 32'(MAX_MODULUS));
    assign mod_ext = 32'(modulus);

    assign q_s    = CW'(query_n);
    assign h_s    = $signed(CW'(active_half_reg));
    assign q_sum  = q_s + h_s;
    assign q_addr = q_sum[AW-1:0];

    assign sts.idx_last = (idx_reg == last_idx);
    assign sts.div_last = (bit_reg == '0);
    assign sts.mod_bad  = (modulus == '0) || (mod_ext > 32'(MAX_MODULUS));
    assign sts.q_out    = (q_s > h_s) || (q_s < -h_s);

    // One restoring-remainder step of H mod m
    assign m_wide   = DW'(m_reg);
    assign trial    = {rem_reg[DW-2:0], active_half_reg[bit_reg]};
    assign rem_next = (trial >= m_wide) ? (trial - m_wide) : trial;

    // Start residue (-H mod m) and residue advance
    assign rem_low = rem_reg[MW:0];
    assign m_diff  = m_reg - rem_low;
    assign r_start = (rem_low == '0) ? '0 : m_diff[MW-1:0];
    assign r_inc   = {1'b0, r_reg} + 1'b1;
    assign r_step  = (r_inc == m_reg) ? '0 : r_inc[MW-1:0];

    // Clear an alive entry whose residue kills it
    assign kill_hit = p_valid_reg && started_reg && kill_rd && alive_rd;

    always_comb
    begin
        priority if (cmd.latch_half)
        begin
            count_next = {h_new, 1'b0};
        end
        else if (kill_hit)
        begin
            count_next = count_reg - 1'b1;
        end
        else
        begin
            count_next = count_reg;
        end
    end

    // Alive map ports: fill pass or sweep write-back; query or sweep read
    assign alive_wr_en   = cmd.fill || kill_hit;
    assign alive_wr_addr = cmd.fill ? idx_reg : p_idx_reg;
    assign alive_wr_data = cmd.fill ? (idx_reg != AW'(active_half_reg)) : 1'b0;
    assign alive_rd_addr = cmd.query_issue ? q_addr : idx_reg;

    assign kill_wr_en = cmd.mask_write && res_ok;

    rms_ram #(
        .WIDTH (1),
        .DEPTH (SPAN)
    ) u_alive_ram (
        .clk     (clk),
        .wr_en   (alive_wr_en),
        .wr_addr (alive_wr_addr),
        .wr_data (alive_wr_data),
        .rd_addr (alive_rd_addr),
        .rd_data (alive_rd)
    );

    rms_ram #(
        .WIDTH (1),
        .DEPTH (MAX_MODULUS)
    ) u_kill_ram (
        .clk     (clk),
        .wr_en   (kill_wr_en),
        .wr_addr (res_ext[MW-1:0]),
        .wr_data (kill_bit),
        .rd_addr (r_reg),
        .rd_data (kill_rd)
    );

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            range_half_reg  <= rms_pkg::HALF_W'(rms_pkg::RANGE_HALF_RESET);
            active_half_reg <= HW'(RESET_HALF);
            started_reg     <= 1'b0;
            count_reg       <= '0;
            p_valid_reg     <= 1'b0;
            done_reg        <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                range_half_reg <= cfg_data;
            end
            if (cmd.latch_half)
            begin
                active_half_reg <= h_new;
                started_reg     <= 1'b1;
            end
            count_reg   <= count_next;
            p_valid_reg <= cmd.sweep_issue;
            done_reg    <= cmd.finish;
        end
    end

    // Working and result registers
    assign cnt_ext = 32'(count_next);

    always_ff @(posedge clk)
    begin
        if (cmd.latch_half || cmd.r_init)
        begin
            idx_reg <= '0;
        end
        else if (cmd.fill || cmd.sweep_issue)
        begin
            idx_reg <= idx_reg + 1'b1;
        end
        p_idx_reg <= idx_reg;

        if (cmd.div_init)
        begin
            m_reg   <= mod_ext[MW:0];
            rem_reg <= '0;
            bit_reg <= BCW'(HW - 1);
        end
        else if (cmd.div_step)
        begin
            rem_reg <= rem_next;
            bit_reg <= bit_reg - 1'b1;
        end

        if (cmd.r_init)
        begin
            r_reg <= r_start;
        end
        else if (cmd.sweep_issue)
        begin
            r_reg <= r_step;
        end

        if (cmd.finish)
        begin
            survivors_reg <= cnt_ext[rms_pkg::SURV_W-1:0];
            alive_reg     <= cmd.fin_query && started_reg && alive_rd;
            error_reg     <= cmd.fin_error;
        end
    end

    assign cfg_ready   = 1'b1;
    assign done        = done_reg;
    assign survivors   = survivors_reg;
    assign alive_bit   = alive_reg;
    assign range_error = error_reg;

endmodule

`default_nettype wire

>>> src/residue_mask_range_sieve.sv
// Top level of the residue mask range sieve: controller plus datapath.
// Depends on rms_pkg, rms_ctrl, rms_datapath, rms_ram.
//
// Usage:
//   Items are transferred at a clock edge with start high and busy low.
//   Every item gives one result: done is high for exactly one cycle with
//   survivors, alive_bit and range_error valid. The receiver cannot stall.
//   range_half is written through cfg_valid/cfg_ready/cfg_data (always ready)
//   and takes effect at the next start item.
// Work from transfer to done, with H the latched half range and
// HW = clog2(MAX_HALF_RANGE+1) (11 by default):
//   mask write, rejected sweep, out-of-range query: no busy phase
//   in-range query: registered alive map read
//   start: one alive map write per entry
//   sweep: HW steps of bit-serial H mod m, one setup step,
//   one pipelined read-modify-write per alive map entry, one drain step.
// One item is in work at a time; the next may be transferred in the cycle
// that done is high. Reset empties the alive map logically (nothing alive,
// survivor count zero) with no clearing pass; the kill mask is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module residue_mask_range_sieve #(
    parameter int MAX_HALF_RANGE = rms_pkg::MAX_HALF_RANGE_DEF,
    parameter int MAX_MODULUS    = rms_pkg::MAX_MODULUS_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                start,
    output logic                                     busy,
    input  wire logic [rms_pkg::ACTION_W-1:0]        action,
    input  wire logic [rms_pkg::RESIDUE_W-1:0]       residue,
    input  wire logic                                kill_bit,
    input  wire logic [rms_pkg::MODULUS_W-1:0]       modulus,
    input  wire logic signed [rms_pkg::QUERY_W-1:0]  query_n,
    output logic                                     done,
    output logic [rms_pkg::SURV_W-1:0]               survivors,
    output logic                                     alive_bit,
    output logic                                     range_error,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [rms_pkg::HALF_W-1:0]          cfg_data
);

    rms_pkg::rms_cmd_t    cmd;
    rms_pkg::rms_status_t sts;

    // Sequence each item
    rms_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .action (action),
        .sts    (sts),
        .cmd    (cmd),
        .busy   (busy)
    );

    // Hold the maps, count and results
    rms_datapath #(
        .MAX_HALF_RANGE (MAX_HALF_RANGE),
        .MAX_MODULUS    (MAX_MODULUS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .residue     (residue),
        .kill_bit    (kill_bit),
        .modulus     (modulus),
        .query_n     (query_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .done        (done),
        .survivors   (survivors),
        .alive_bit   (alive_bit),
        .range_error (range_error)
    );

endmodule

`default_nettype wire

>>> src/rms_checker.sv
// Port-level checker for the residue mask range sieve, bound to the top level.
// Depends on residue_mask_range_sieve_assert.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "residue_mask_range_sieve_assert.svh"

module rms_checker (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic start,
    input wire logic busy,
    input wire logic done,
    input wire logic alive_bit,
    input wire logic range_error
);

    // A transferred item either finishes at once or keeps the block busy
    `RMS_ASSERT_NEXT(a_item_progress, start && !busy, done || busy)

    // A result is only shown once the block has gone idle
    `RMS_ASSERT_IMPL(a_done_idle, done, !busy)

    // Leaving a multi-cycle item always delivers its result
    `RMS_ASSERT_IMPL(a_busy_fall_done, $fell(busy), done)

    // An out-of-range query never reports an alive entry
    `RMS_ASSERT_IMPL(a_error_not_alive, done && range_error, !alive_bit)

endmodule

bind residue_mask_range_sieve rms_checker u_rms_checker (.*);

`default_nettype wire
